// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers shared by the RTL; compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define ASSERT_CK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
// Condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CK(lbl, prop)
`define ASSERT_NEVER(lbl, cond)
`endif

`endif

// ===== rtl/core/gnfp_pkg.sv =====
// ----------------------------------------------------------------------------
// GNSS navigation frame parser package
// Frame constants, parser phase codes and the navigation record field layout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gnfp_pkg;

  // Default payload store depth in bytes
  localparam int unsigned PayloadDepthDef = 128;

  // Frame constants
  localparam logic [7:0]  SyncFirst  = 8'hB5;
  localparam logic [7:0]  SyncSecond = 8'h62;
  localparam logic [7:0]  ClassNav   = 8'h01;
  localparam logic [7:0]  IdPvt      = 8'h07;
  localparam logic [15:0] PvtMinLen  = 16'd92;
  localparam logic [7:0]  Fix3dMin   = 8'd3;
  localparam logic [6:0]  FixOffset  = 7'd20;
  localparam logic [4:0]  LastField  = 5'd18;

  // Parser phases
  typedef enum logic [3:0] {
    PH_SYNC1,
    PH_SYNC2,
    PH_CLASS,
    PH_ID,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_PAYLOAD,
    PH_CK_A,
    PH_CK_B,
    PH_EMIT_RD,
    PH_EMIT_CAP
  } phase_e;

  // Result kinds
  typedef enum logic {
    EV_RECORD    = 1'b0,
    EV_CKSUM_ERR = 1'b1
  } event_e;

  // Payload offset of a record field
  function automatic logic [6:0] fld_off(logic [4:0] k);
    logic [6:0] o;
    case (k)
      5'd0:    o = 7'd4;
      5'd1:    o = 7'd6;
      5'd2:    o = 7'd7;
      5'd3:    o = 7'd8;
      5'd4:    o = 7'd9;
      5'd5:    o = 7'd10;
      5'd6:    o = 7'd20;
      5'd7:    o = 7'd23;
      5'd8:    o = 7'd24;
      5'd9:    o = 7'd28;
      5'd10:   o = 7'd32;
      5'd11:   o = 7'd36;
      5'd12:   o = 7'd40;
      5'd13:   o = 7'd44;
      5'd14:   o = 7'd48;
      5'd15:   o = 7'd52;
      5'd16:   o = 7'd56;
      5'd17:   o = 7'd60;
      5'd18:   o = 7'd64;
      default: o = 7'd0;
    endcase
    return o;
  endfunction

  // Index of the last byte of a record field (size minus one)
  function automatic logic [1:0] fld_last_byte(logic [4:0] k);
    logic [1:0] n;
    case (k)
      5'd0:                                      n = 2'd1;
      5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7:  n = 2'd0;
      default:                                   n = 2'd3;
    endcase
    return n;
  endfunction

  // Field is sign-extended
  function automatic logic fld_signed(logic [4:0] k);
    logic s;
    case (k)
      5'd8, 5'd9, 5'd10, 5'd11, 5'd14, 5'd15, 5'd16, 5'd17, 5'd18: s = 1'b1;
      default: s = 1'b0;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/core/gnfp_if.sv =====
// ----------------------------------------------------------------------------
// GNSS navigation frame parser channels
// Valid/ready channels for received bytes and for decoded result events.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Received byte channel
interface gnfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// Result event channel
interface gnfp_out_if;
  logic               valid;
  logic               ready;
  logic               event_kind;
  logic [4:0]         field_index;
  logic signed [32:0] field_value;
  logic               fix_3d;
  logic [31:0]        frame_count;
  logic [31:0]        error_count;
  logic               last;

  modport source (output valid, output event_kind, output field_index,
                  output field_value, output fix_3d, output frame_count,
                  output error_count, output last, input ready);
  modport sink   (input valid, input event_kind, input field_index,
                  input field_value, input fix_3d, input frame_count,
                  input error_count, input last, output ready);
endinterface

// ===== rtl/core/gnss_nav_frame_parser.sv =====
// ----------------------------------------------------------------------------
// GNSS navigation frame parser
// Byte-serial binary frame parser with payload store, Fletcher checksum and
// navigation record field decode.
// ----------------------------------------------------------------------------
//   Port     Dir  Transaction
//   rx_i     in   one received byte (rx_byte)
//   ev_o     out  one record field or one checksum error event
//
// Header, length and payload bytes are taken at one per cycle. A checksum
// byte is taken only when the result register can accept an error event.
// A record burst reads the payload store through its single read port,
// alternating a read state and a capture state per byte: 53 reads for
// 19 results, stalling on a low ready. No bytes are taken during the burst.
// Reset returns the parser to sync hunting with all counters cleared; the
// payload store is not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gnss_nav_frame_parser #(
  parameter int unsigned PAYLOAD_DEPTH = gnfp_pkg::PayloadDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  gnfp_in_if.sink          rx_i,
  gnfp_out_if.source       ev_o
);
  import gnfp_pkg::*;

  localparam int unsigned AddrW = $clog2(PAYLOAD_DEPTH);
  localparam int unsigned CntW  = $clog2(PAYLOAD_DEPTH + 1);

  // Control state
  phase_e        phase_q, phase_d;
  logic [7:0]    class_q, class_d;
  logic [7:0]    id_q, id_d;
  logic [15:0]   len_q, len_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]    sum_a_q, sum_a_d;
  logic [7:0]    sum_b_q, sum_b_d;
  logic [7:0]    fixb_q, fixb_d;
  logic [31:0]   good_q, good_d;
  logic [31:0]   bad_q, bad_d;
  logic          fix_q, fix_d;
  logic [4:0]    fld_q, fld_d;
  logic [1:0]    bsel_q, bsel_d;
  logic [31:0]   acc_q, acc_d;
  logic          out_valid_q, out_valid_d;

  // Result payload
  logic               kind_q, kind_d;
  logic [4:0]         idx_q, idx_d;
  logic signed [32:0] val_q, val_d;
  logic               ofix_q, ofix_d;
  logic [31:0]        ofcnt_q, ofcnt_d;
  logic [31:0]        oecnt_q, oecnt_d;
  logic               last_q, last_d;

  // Payload store
  logic [7:0]       mem_q [PAYLOAD_DEPTH];
  logic [7:0]       rd_q;
  logic             mem_we, mem_re;
  logic [AddrW-1:0] waddr, raddr;

  logic        in_fire, in_ready, out_free, ck_phase, emitting;
  logic [7:0]  b;
  logic [7:0]  sum_a_add;
  logic [7:0]  sum_b_add;
  logic [15:0] len_full;
  logic [CntW-1:0] cnt_inc;
  logic        is_pvt, field_done, emit_load, err_load, rec_start;
  logic [31:0] byte_sh, cur_word;
  logic        fld_is_last;

  // Handshake and decode terms
  assign b         = rx_i.rx_byte;
  assign out_free  = !out_valid_q || ev_o.ready;
  assign ck_phase  = (phase_q == PH_CK_A) || (phase_q == PH_CK_B);
  assign emitting  = (phase_q == PH_EMIT_RD) || (phase_q == PH_EMIT_CAP);
  assign in_ready  = !emitting && (!ck_phase || out_free);
  assign in_fire   = rx_i.valid && in_ready;
  assign rx_i.ready = in_ready;

  assign sum_a_add = sum_a_q + b;
  assign sum_b_add = sum_b_q + sum_a_add;
  assign len_full  = {b, len_q[7:0]};
  assign cnt_inc   = cnt_q + CntW'(1);
  assign is_pvt    = (class_q == ClassNav) && (id_q == IdPvt) && (len_q >= PvtMinLen);

  assign fld_is_last = (fld_q == LastField);
  assign field_done  = (phase_q == PH_EMIT_CAP) && (bsel_q == fld_last_byte(fld_q));
  assign emit_load   = field_done && out_free;
  assign err_load    = in_fire && (((phase_q == PH_CK_A) && (b != sum_a_q)) ||
                                   ((phase_q == PH_CK_B) && (b != sum_b_q)));
  assign rec_start   = in_fire && (phase_q == PH_CK_B) && (b == sum_b_q) && is_pvt;

  // Assemble the field word from the byte just read
  assign byte_sh  = {24'h0, rd_q} << {bsel_q, 3'b000};
  assign cur_word = (bsel_q == 2'd0) ? {24'h0, rd_q} : (acc_q | byte_sh);

  // Store addresses
  assign waddr = cnt_q[AddrW-1:0];
  assign raddr = AddrW'(fld_off(fld_q)) + AddrW'(bsel_q);

  // Next parser phase
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      PH_SYNC1: begin
        if (in_fire && (b == SyncFirst)) phase_d = PH_SYNC2;
      end
      PH_SYNC2: begin
        if (in_fire) phase_d = (b == SyncSecond) ? PH_CLASS : PH_SYNC1;
      end
      PH_CLASS: begin
        if (in_fire) phase_d = PH_ID;
      end
      PH_ID: begin
        if (in_fire) phase_d = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        if (in_fire) phase_d = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        if (in_fire) begin
          if (len_full > 16'(PAYLOAD_DEPTH)) phase_d = PH_SYNC1;
          else if (len_full == 16'd0)        phase_d = PH_CK_A;
          else                               phase_d = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (in_fire && (16'(cnt_inc) >= len_q)) phase_d = PH_CK_A;
      end
      PH_CK_A: begin
        if (in_fire) phase_d = (b == sum_a_q) ? PH_CK_B : PH_SYNC1;
      end
      PH_CK_B: begin
        if (in_fire) phase_d = rec_start ? PH_EMIT_RD : PH_SYNC1;
      end
      PH_EMIT_RD: begin
        phase_d = PH_EMIT_CAP;
      end
      PH_EMIT_CAP: begin
        if (!field_done)   phase_d = PH_EMIT_RD;
        else if (out_free) phase_d = fld_is_last ? PH_SYNC1 : PH_EMIT_RD;
      end
      default: begin
        phase_d = PH_SYNC1;
      end
    endcase
  end

  // Datapath and result register loads
  always_comb begin
    class_d = class_q;
    id_d    = id_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    sum_a_d = sum_a_q;
    sum_b_d = sum_b_q;
    fixb_d  = fixb_q;
    good_d  = good_q;
    bad_d   = bad_q;
    fix_d   = fix_q;
    fld_d   = fld_q;
    bsel_d  = bsel_q;
    acc_d   = acc_q;
    mem_we  = 1'b0;
    mem_re  = 1'b0;

    case (phase_q)
      PH_CLASS: begin
        if (in_fire) begin
          class_d = b;
          sum_a_d = b;
          sum_b_d = b;
        end
      end
      PH_ID: begin
        if (in_fire) begin
          id_d    = b;
          sum_a_d = sum_a_add;
          sum_b_d = sum_b_add;
        end
      end
      PH_LEN_LO: begin
        if (in_fire) begin
          len_d   = {8'h00, b};
          sum_a_d = sum_a_add;
          sum_b_d = sum_b_add;
        end
      end
      PH_LEN_HI: begin
        if (in_fire) begin
          len_d   = len_full;
          cnt_d   = '0;
          sum_a_d = sum_a_add;
          sum_b_d = sum_b_add;
        end
      end
      PH_PAYLOAD: begin
        if (in_fire) begin
          mem_we  = 1'b1;
          cnt_d   = cnt_inc;
          sum_a_d = sum_a_add;
          sum_b_d = sum_b_add;
          if (cnt_q == CntW'(FixOffset)) fixb_d = b;
        end
      end
      PH_CK_B: begin
        if (rec_start) begin
          good_d = good_q + 32'd1;
          fix_d  = (fixb_q >= Fix3dMin);
          fld_d  = '0;
          bsel_d = '0;
        end
      end
      PH_EMIT_RD: begin
        mem_re = 1'b1;
      end
      PH_EMIT_CAP: begin
        acc_d = cur_word;
        if (!field_done) begin
          bsel_d = bsel_q + 2'd1;
        end else if (out_free) begin
          fld_d  = fld_q + 5'd1;
          bsel_d = '0;
        end
      end
      default: begin
      end
    endcase

    if (err_load) bad_d = bad_q + 32'd1;
  end

  // Result register: drop on take, load an error or a record field
  always_comb begin
    out_valid_d = out_valid_q && !ev_o.ready;
    kind_d  = kind_q;
    idx_d   = idx_q;
    val_d   = val_q;
    ofix_d  = ofix_q;
    ofcnt_d = ofcnt_q;
    oecnt_d = oecnt_q;
    last_d  = last_q;
    if (err_load) begin
      out_valid_d = 1'b1;
      kind_d  = EV_CKSUM_ERR;
      idx_d   = '0;
      val_d   = '0;
      ofix_d  = fix_q;
      ofcnt_d = good_q;
      oecnt_d = bad_q + 32'd1;
      last_d  = 1'b1;
    end else if (emit_load) begin
      out_valid_d = 1'b1;
      kind_d  = EV_RECORD;
      idx_d   = fld_q;
      val_d   = fld_signed(fld_q) ? {cur_word[31], cur_word} : {1'b0, cur_word};
      ofix_d  = fix_q;
      ofcnt_d = good_q;
      oecnt_d = bad_q;
      last_d  = fld_is_last;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SYNC1;
      class_q     <= '0;
      id_q        <= '0;
      len_q       <= '0;
      cnt_q       <= '0;
      sum_a_q     <= '0;
      sum_b_q     <= '0;
      fixb_q      <= '0;
      good_q      <= '0;
      bad_q       <= '0;
      fix_q       <= 1'b0;
      fld_q       <= '0;
      bsel_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      class_q     <= class_d;
      id_q        <= id_d;
      len_q       <= len_d;
      cnt_q       <= cnt_d;
      sum_a_q     <= sum_a_d;
      sum_b_q     <= sum_b_d;
      fixb_q      <= fixb_d;
      good_q      <= good_d;
      bad_q       <= bad_d;
      fix_q       <= fix_d;
      fld_q       <= fld_d;
      bsel_q      <= bsel_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    kind_q  <= kind_d;
    idx_q   <= idx_d;
    val_q   <= val_d;
    ofix_q  <= ofix_d;
    ofcnt_q <= ofcnt_d;
    oecnt_q <= oecnt_d;
    last_q  <= last_d;
  end

  // Payload store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[waddr] <= b;
    if (mem_re) rd_q <= mem_q[raddr];
  end

  // Drive the result channel
  assign ev_o.valid       = out_valid_q;
  assign ev_o.event_kind  = kind_q;
  assign ev_o.field_index = idx_q;
  assign ev_o.field_value = val_q;
  assign ev_o.fix_3d      = ofix_q;
  assign ev_o.frame_count = ofcnt_q;
  assign ev_o.error_count = oecnt_q;
  assign ev_o.last        = last_q;

  // Store writes and burst reads never share a cycle
  `ASSERT_NEVER(a_no_rw_overlap, mem_we && mem_re)
  // The last record field ends the burst
  `ASSERT_CK(a_burst_end, (emit_load && fld_is_last) |=> (phase_q == PH_SYNC1))
  // Frame counter moves only by one, and only at a record start
  `ASSERT_CK(a_good_step, (good_q != $past(good_q)) |->
             ((good_q == $past(good_q) + 32'd1) && $past(rec_start)))
  // Error counter moves only with an error event
  `ASSERT_CK(a_bad_step, (bad_q != $past(bad_q)) |->
             ($past(err_load) && out_valid_q && (kind_q == EV_CKSUM_ERR)))
  // A loaded error or record event never overwrites an untaken result
  `ASSERT_NEVER(a_no_clobber, (err_load || emit_load) && out_valid_q && !ev_o.ready)

endmodule

// ===== tb/gnss_nav_frame_parser_tb.sv =====
// ----------------------------------------------------------------------------
// GNSS navigation frame parser testbench
// Feeds sync noise, header-only, short, oversized and NAV-PVT frames through
// the byte channel, predicts every record field and checksum error event, and
// compares each result transaction against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gnss_nav_frame_parser_tb;
  import gnfp_pkg::*;

  localparam int unsigned PayloadDepth = PayloadDepthDef;
  localparam int unsigned NumFields    = 19;
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned DrainCycles  = 300;
  localparam int unsigned HoldOffLen   = 600;
  localparam int unsigned RandomBytes  = 500;
  localparam int unsigned MaxReports   = 60;

  // Checksum corruption applied by the frame builder
  typedef enum logic [1:0] {
    CK_GOOD,
    CK_BAD_A,
    CK_BAD_B
  } ck_fault_e;

  // Payload fill patterns
  typedef enum logic [1:0] {
    BODY_RANDOM,
    BODY_ZERO,
    BODY_ONES
  } body_fill_e;

  // One predicted result transaction
  typedef struct {
    event_e             kind;
    logic [4:0]         index;
    logic signed [32:0] value;
    logic               fix;
    logic [31:0]        frames;
    logic [31:0]        errors;
    logic               last;
  } nav_event_t;

  logic clk_i;
  logic rst_ni;

  gnfp_in_if  rx_if ();
  gnfp_out_if ev_if ();

  gnss_nav_frame_parser i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .ev_o   (ev_if)
  );

  // Record layout: payload offset, byte count and sign extension per field
  int unsigned field_offset [NumFields] = '{4, 6, 7, 8, 9, 10, 20, 23, 24, 28, 32, 36, 40,
                                           44, 48, 52, 56, 60, 64};
  int unsigned field_size   [NumFields] = '{2, 1, 1, 1, 1, 1, 1, 1, 4, 4, 4, 4, 4, 4, 4, 4,
                                           4, 4, 4};
  bit          field_signed [NumFields] = '{0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 1, 1, 0, 0, 1, 1,
                                           1, 1, 1};

  // Parser shadow state
  phase_e      p_phase;
  logic [7:0]  p_class;
  logic [7:0]  p_id;
  logic [15:0] p_len;
  int unsigned p_count;
  logic [7:0]  p_store [PayloadDepth];
  logic [7:0]  p_sum_a;
  logic [7:0]  p_sum_b;
  logic [31:0] p_good;
  logic [31:0] p_bad;
  logic        p_fix;

  nav_event_t  expected_events [$];

  // Stimulus and checking bookkeeping
  logic [7:0]  frame_body [PayloadDepth];
  bit          steady;
  int unsigned hold_cycles;
  int unsigned bytes_sent;
  int unsigned mismatches;
  int unsigned cycle_cnt;

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic void fletcher_add(logic [7:0] b);
    p_sum_a = p_sum_a + b;
    p_sum_b = p_sum_b + p_sum_a;
  endfunction

  function automatic void push_cksum_error();
    nav_event_t e;
    p_bad   = p_bad + 1;
    e.kind   = EV_CKSUM_ERR;
    e.index  = '0;
    e.value  = '0;
    e.fix    = p_fix;
    e.frames = p_good;
    e.errors = p_bad;
    e.last   = 1'b1;
    expected_events.push_back(e);
  endfunction

  function automatic void push_nav_record();
    nav_event_t  e;
    logic [31:0] raw;
    // Ignore anything that is not a full NAV-PVT frame
    if (p_class != ClassNav || p_id != IdPvt || p_len < PvtMinLen) return;
    p_fix  = (p_store[FixOffset] >= Fix3dMin);
    p_good = p_good + 1;
    for (int k = 0; k < NumFields; k++) begin
      raw = '0;
      for (int j = 0; j < field_size[k]; j++) begin
        raw |= 32'(p_store[field_offset[k] + j]) << (8 * j);
      end
      e.kind   = EV_RECORD;
      e.index  = 5'(k);
      e.value  = {field_signed[k] & raw[31], raw};
      e.fix    = p_fix;
      e.frames = p_good;
      e.errors = p_bad;
      e.last   = (k == NumFields - 1);
      expected_events.push_back(e);
    end
  endfunction

  function automatic void predict_byte(logic [7:0] b);
    case (p_phase)
      PH_SYNC1: begin
        if (b == SyncFirst) p_phase = PH_SYNC2;
      end
      PH_SYNC2: begin
        // A bad second sync byte is never taken as a new first one
        p_phase = (b == SyncSecond) ? PH_CLASS : PH_SYNC1;
      end
      PH_CLASS: begin
        p_class = b;
        p_sum_a = '0;
        p_sum_b = '0;
        fletcher_add(b);
        p_phase = PH_ID;
      end
      PH_ID: begin
        p_id = b;
        fletcher_add(b);
        p_phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        p_len = {8'h00, b};
        fletcher_add(b);
        p_phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        p_len[15:8] = b;
        fletcher_add(b);
        if (p_len > PayloadDepth) begin
          p_phase = PH_SYNC1;
        end else if (p_len == 0) begin
          p_phase = PH_CK_A;
        end else begin
          p_count = 0;
          p_phase = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (p_count < PayloadDepth) p_store[p_count] = b;
        p_count++;
        fletcher_add(b);
        if (p_count >= p_len) p_phase = PH_CK_A;
      end
      PH_CK_A: begin
        if (b == p_sum_a) begin
          p_phase = PH_CK_B;
        end else begin
          push_cksum_error();
          p_phase = PH_SYNC1;
        end
      end
      PH_CK_B: begin
        if (b == p_sum_b) push_nav_record();
        else push_cksum_error();
        p_phase = PH_SYNC1;
      end
      default: begin
        p_phase = PH_SYNC1;
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Byte sender
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b);
    // Idle at random, then hold the byte until the parser takes it
    while (!steady && $urandom_range(99) < 13) begin
      rx_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk_i); while (!rx_if.ready);
    predict_byte(b);
    bytes_sent++;
  endtask

  function automatic void fill_body(body_fill_e fill);
    for (int i = 0; i < PayloadDepth; i++) begin
      case (fill)
        BODY_ZERO: frame_body[i] = 8'h00;
        BODY_ONES: frame_body[i] = 8'hFF;
        default:   frame_body[i] = 8'($urandom);
      endcase
    end
  endfunction

  // Send sync, header, body and checksum; an oversized frame stops after its length
  task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                            input logic [15:0] len, input ck_fault_e fault);
    logic [7:0] hdr [4];
    logic [7:0] ck_a;
    logic [7:0] ck_b;
    hdr  = '{cls, id, len[7:0], len[15:8]};
    ck_a = '0;
    ck_b = '0;
    send_byte(SyncFirst);
    send_byte(SyncSecond);
    foreach (hdr[i]) begin
      send_byte(hdr[i]);
      ck_a = ck_a + hdr[i];
      ck_b = ck_b + ck_a;
    end
    if (len > PayloadDepth) return;
    for (int i = 0; i < len; i++) begin
      send_byte(frame_body[i]);
      ck_a = ck_a + frame_body[i];
      ck_b = ck_b + ck_a;
    end
    if (fault == CK_BAD_A) ck_a = ck_a ^ 8'($urandom_range(1, 255));
    if (fault == CK_BAD_B) ck_b = ck_b ^ 8'($urandom_range(1, 255));
    send_byte(ck_a);
    send_byte(ck_b);
  endtask

  task automatic send_nav(input logic [15:0] len, input logic [7:0] fix_code,
                          input ck_fault_e fault);
    frame_body[FixOffset] = fix_code;
    send_frame(ClassNav, IdPvt, len, fault);
  endtask

  function automatic ck_fault_e pick_fault(int unsigned good_pct);
    if ($urandom_range(99) < good_pct) return CK_GOOD;
    return $urandom_range(1) ? CK_BAD_A : CK_BAD_B;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    if (mismatches <= MaxReports) begin
      $display("%0t ns: %s differs: got %0h want %0h", $time, what, got, want);
    end
  endtask

  task automatic check_event();
    nav_event_t e;
    if (expected_events.size() == 0) begin
      report_mismatch("unpredicted result, field_index", ev_if.field_index, '0);
      return;
    end
    e = expected_events.pop_front();
    if (ev_if.event_kind !== e.kind) report_mismatch("event_kind", ev_if.event_kind, e.kind);
    if (ev_if.field_index !== e.index) report_mismatch("field_index", ev_if.field_index, e.index);
    if (ev_if.field_value !== e.value) begin
      report_mismatch("field_value", 64'(ev_if.field_value), 64'(e.value));
    end
    if (ev_if.fix_3d !== e.fix) report_mismatch("fix_3d", ev_if.fix_3d, e.fix);
    if (ev_if.frame_count !== e.frames) report_mismatch("frame_count", ev_if.frame_count, e.frames);
    if (ev_if.error_count !== e.errors) report_mismatch("error_count", ev_if.error_count, e.errors);
    if (ev_if.last !== e.last) report_mismatch("last", ev_if.last, e.last);
  endtask

  // Take results; hold ready low while a hold-off is counting down
  initial begin : result_sink
    ev_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (ev_if.valid && ev_if.ready) check_event();
      if (hold_cycles > 0) begin
        hold_cycles--;
        ev_if.ready <= 1'b0;
      end else begin
        ev_if.ready <= steady || ($urandom_range(99) >= 13);
      end
    end
  end

  // Stop a hung run
  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt <= CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("gnss_nav_frame_parser: mismatch");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Sync hunting and header-only frames
  task automatic test_sync_hunt();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(SyncSecond);
    send_byte(SyncFirst);
    send_byte(SyncFirst);
    send_byte(SyncSecond);
    send_byte(SyncFirst);
    send_byte(8'h00);
    send_frame(8'hFF, 8'hFF, 16'd0, CK_GOOD);
    send_frame(8'h00, 8'h00, 16'd0, CK_BAD_A);
    send_frame(ClassNav, IdPvt, 16'd0, CK_BAD_B);
  endtask

  // Oversized, full-store and unused frames
  task automatic test_frame_lengths();
    fill_body(BODY_RANDOM);
    send_frame(8'h0A, 8'h05, 16'(PayloadDepth + 1), CK_GOOD);
    send_byte(8'h5A);
    send_frame(ClassNav, IdPvt, 16'hFFFF, CK_GOOD);
    send_frame(ClassNav, IdPvt, 16'h0100, CK_GOOD);
    send_frame(8'h0A, 8'h05, 16'(PayloadDepth), CK_GOOD);
    send_frame(ClassNav, IdPvt, PvtMinLen - 16'd1, CK_GOOD);
    send_frame(ClassNav, 8'h08, PvtMinLen, CK_GOOD);
    send_frame(8'h02, IdPvt, PvtMinLen, CK_GOOD);
    send_frame(8'h05, 8'h01, 16'd1, CK_BAD_B);
  endtask

  // NAV-PVT records: sign extension, fix flag threshold, checksum faults
  task automatic test_nav_records();
    fill_body(BODY_ONES);
    send_nav(PvtMinLen, 8'hFF, CK_GOOD);
    fill_body(BODY_ZERO);
    send_nav(PvtMinLen, 8'h00, CK_GOOD);
    fill_body(BODY_RANDOM);
    send_nav(PvtMinLen, Fix3dMin - 8'd1, CK_GOOD);
    send_nav(16'(PayloadDepth), Fix3dMin, CK_GOOD);
    send_nav(16'd100, Fix3dMin, CK_BAD_A);
    send_nav(PvtMinLen, 8'h02, CK_BAD_B);
  endtask

  // Hold the result side off while records keep arriving
  task automatic test_backpressure();
    hold_cycles = HoldOffLen;
    repeat (4) begin
      fill_body(BODY_RANDOM);
      send_nav(PvtMinLen, 8'($urandom_range(0, 5)), CK_GOOD);
    end
  endtask

  // Mostly well-formed frames with random content, some noise and broken syncs
  task automatic test_random_traffic();
    int unsigned start;
    int unsigned pick;
    int unsigned sent;
    start = bytes_sent;
    while (bytes_sent - start < RandomBytes) begin
      sent   = bytes_sent - start;
      steady = (sent >= 200 && sent < 320);
      pick   = $urandom_range(99);
      fill_body(BODY_RANDOM);
      if (pick < 20) begin
        send_nav(($urandom_range(9) == 0) ? 16'($urandom_range(PvtMinLen, PayloadDepth))
                                          : 16'($urandom_range(PvtMinLen, PvtMinLen + 4)),
                 ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5)),
                 pick_fault(70));
      end else if (pick < 55) begin
        if ($urandom_range(3) == 0) begin
          send_frame(ClassNav, IdPvt, 16'($urandom_range(0, 16)), pick_fault(50));
        end else begin
          send_frame(8'($urandom), 8'($urandom), 16'($urandom_range(0, 16)),
                     pick_fault(50));
        end
      end else if (pick < 70) begin
        send_frame(8'($urandom), 8'($urandom),
                   16'($urandom_range(PayloadDepth + 1, 16'hFFFF)), CK_GOOD);
      end else if (pick < 85) begin
        send_byte(SyncFirst);
        send_byte(($urandom_range(1) == 0) ? SyncFirst : 8'($urandom_range(0, 8'h61)));
      end else begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
      end
    end
    steady = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    rst_ni        = 1'b0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    steady        = 1'b0;
    hold_cycles   = 0;
    bytes_sent    = 0;
    mismatches    = 0;
    p_phase       = PH_SYNC1;
    p_class       = '0;
    p_id          = '0;
    p_len         = '0;
    p_count       = 0;
    p_sum_a       = '0;
    p_sum_b       = '0;
    p_good        = '0;
    p_bad         = '0;
    p_fix         = 1'b0;
    foreach (p_store[i]) p_store[i] = '0;

    // Release reset once the clock is running
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_sync_hunt();
    test_frame_lengths();
    test_nav_records();
    test_backpressure();
    test_random_traffic();

    // Drain outstanding results, then let any late burst show up
    rx_if.valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("gnss_nav_frame_parser: match");
    end else begin
      $display("gnss_nav_frame_parser: mismatch");
    end
    $finish;
  end

endmodule
